// ===== rtl/pmc_pkg.sv =====
package pmc_pkg;

   localparam int unsigned ECHO_WIDTH_DEFAULT = 16;
   localparam int unsigned LIMIT_W = 11;
   localparam int unsigned DIST_W = 11;
   localparam int unsigned EVENT_W = 3;
   localparam int unsigned RSP_DATA_W = 24;

   localparam int unsigned SOUND_NUM = 34;
   localparam int unsigned SOUND_DEN = 2000;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd10;
   localparam logic [DIST_W-1:0] DIST_MAX = 11'd2047;

   typedef enum logic [1:0] {
      ST_NORMAL   = 2'd0,
      ST_MANUAL   = 2'd1,
      ST_DISABLED = 2'd2,
      ST_ALERT    = 2'd3
   } state_type;

   typedef enum logic [EVENT_W-1:0] {
      EV_ECHO    = 3'd0,
      EV_SWITCH  = 3'd1,
      EV_SET     = 3'd2,
      EV_RELEASE = 3'd3,
      EV_BLINK   = 3'd4
   } event_type;

endpackage

// ===== rtl/proximity_mode_controller.sv =====
// proximity_mode_controller
//
// Mode controller for an obstacle sensor with normal, manual, disabled and
// alert states plus a remembered base mode (normal or manual).
// req channel: one event per transaction. req_tuser carries the event kind
// (echo measured, switch press, set state, release alert, blink tick);
// req_tdata carries the echo width, the debounced switch level and the
// requested state. rsp channel: one result per event with the state, the
// base mode, the changed flag, both lamp levels and the measured distance.
// csr channel: writes the near limit in cm; always ready, use only while idle.
// From req to rsp an event passes an input register that scales the echo
// by 17, a stage that divides by 1000 with one reciprocal multiplier, and the
// decision stage that updates the state and loads the result register.
// Throughput is one event per cycle; every stage has its own valid and moves
// into a free slot, so a stalled rsp only halts the stages behind it once
// they fill up.
// Reset (synchronous, active high) empties the pipeline, sets the state and
// base mode to normal, the blink phase to 0 and the near limit to 10 cm.
module proximity_mode_controller #(
   parameter int unsigned ECHO_WIDTH = pmc_pkg::ECHO_WIDTH_DEFAULT,
   localparam int unsigned REQ_DATA_W = ((ECHO_WIDTH + 3 + 7) / 8) * 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // echo_us, switch_level, requested_state, zero fill
   input  logic [REQ_DATA_W-1:0]          req_tdata,
   // mode
   input  logic [pmc_pkg::EVENT_W-1:0]    req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // system_state, base_mode, changed, red_led, yellow_led, distance_cm, zero fill
   output logic [pmc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [pmc_pkg::LIMIT_W-1:0]    csr_data
);
   import pmc_pkg::*;

   localparam int unsigned NUM = SOUND_NUM / 2;
   localparam int unsigned DEN = SOUND_DEN / 2;
   localparam int unsigned X_W = ECHO_WIDTH + $clog2(NUM);
   localparam int unsigned SHIFT = X_W + $clog2(DEN);
   localparam int unsigned M_W = SHIFT + 1 - $clog2(DEN);
   localparam int unsigned Q_W = X_W + 1 - $clog2(DEN);
   localparam int unsigned PROD_W = X_W + M_W;
   localparam int unsigned CMP_W = (Q_W > DIST_W) ? Q_W : DIST_W;
   localparam longint unsigned RECIP = ((64'd1 << SHIFT) + DEN - 1) / DEN;

   logic [LIMIT_W-1:0] limit_ff;

   logic               s1_valid_ff;
   event_type          s1_mode_ff;
   logic [X_W-1:0]     s1_x_ff;
   logic               s1_sw_ff;
   logic [1:0]         s1_req_ff;

   logic               s2_valid_ff;
   event_type          s2_mode_ff;
   logic [Q_W-1:0]     s2_q_ff;
   logic               s2_sw_ff;
   logic [1:0]         s2_req_ff;

   logic               out_valid_ff;
   logic [RSP_DATA_W-1:0] out_data_ff;

   state_type          cur_ff, cur_in;
   logic               base_ff, base_in;
   logic               blink_ff, blink_in;
   logic               chg;

   logic               out_ready, s2_ready, s1_ready;
   logic               s2_move;
   logic [X_W-1:0]     x_in;
   logic [PROD_W-1:0]  prod;
   logic [CMP_W-1:0]   q_ext;
   logic [DIST_W-1:0]  dist_sat;
   logic [DIST_W-1:0]  dist_out;
   logic               red, yellow;

   assign out_ready = !out_valid_ff || rsp_tready;
   assign s2_ready = !s2_valid_ff || out_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign s2_move = s2_valid_ff && out_ready;

   assign req_tready = s1_ready;
   assign csr_ready = 1'b1;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = out_data_ff;

   assign x_in = X_W'(req_tdata[ECHO_WIDTH-1:0]) * X_W'(NUM);
   assign prod = PROD_W'(s1_x_ff) * PROD_W'(RECIP);

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_valid) begin
         limit_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= req_tvalid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (out_ready) begin
            out_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && req_tvalid) begin
         s1_mode_ff <= event_type'(req_tuser);
         s1_x_ff <= x_in;
         s1_sw_ff <= req_tdata[ECHO_WIDTH];
         s1_req_ff <= req_tdata[ECHO_WIDTH+2:ECHO_WIDTH+1];
      end
      if (s2_ready && s1_valid_ff) begin
         s2_mode_ff <= s1_mode_ff;
         s2_q_ff <= prod[SHIFT +: Q_W];
         s2_sw_ff <= s1_sw_ff;
         s2_req_ff <= s1_req_ff;
      end
      if (s2_move) begin
         out_data_ff <= RSP_DATA_W'({dist_out, yellow, red, chg, base_in, cur_in});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff <= ST_NORMAL;
         base_ff <= 1'b0;
         blink_ff <= 1'b0;
      end else if (s2_move) begin
         cur_ff <= cur_in;
         base_ff <= base_in;
         blink_ff <= blink_in;
      end
   end

   assign q_ext = CMP_W'(s2_q_ff);
   assign dist_sat = (q_ext > CMP_W'(DIST_MAX)) ? DIST_MAX : q_ext[DIST_W-1:0];

   // next state
   always_comb begin
      state_type target;
      logic      want_go;
      target = cur_ff;
      want_go = 1'b0;
      base_in = base_ff;
      blink_in = blink_ff;
      unique case (s2_mode_ff)
         EV_ECHO: begin
            if (q_ext < CMP_W'(limit_ff)) begin
               target = ST_DISABLED;
               want_go = 1'b1;
            end else if (cur_ff == ST_DISABLED) begin
               target = state_type'({1'b0, base_ff});
               want_go = 1'b1;
            end
         end
         EV_SWITCH: begin
            if (!s2_sw_ff) begin
               unique case (cur_ff)
                  ST_NORMAL: begin
                     target = ST_MANUAL;
                     want_go = 1'b1;
                  end
                  ST_MANUAL: begin
                     target = ST_NORMAL;
                     want_go = 1'b1;
                  end
                  ST_DISABLED: base_in = !base_ff;
                  ST_ALERT: ;
               endcase
            end
         end
         EV_SET: begin
            if (cur_ff != ST_DISABLED) begin
               target = state_type'(s2_req_ff);
               want_go = 1'b1;
            end
         end
         EV_RELEASE: begin
            if (cur_ff == ST_ALERT) begin
               target = state_type'({1'b0, base_ff});
               want_go = 1'b1;
            end
         end
         EV_BLINK: begin
            if (cur_ff == ST_MANUAL || cur_ff == ST_ALERT) begin
               blink_in = !blink_ff;
            end
         end
         default: ;
      endcase
      chg = want_go && (target != cur_ff);
      cur_in = chg ? target : cur_ff;
      if (chg && (target == ST_NORMAL || target == ST_MANUAL)) begin
         base_in = target[0];
      end
      if (chg && (target == ST_MANUAL || target == ST_ALERT)) begin
         blink_in = 1'b1;
      end
   end

   // lamps and distance
   always_comb begin
      red = 1'b0;
      yellow = 1'b0;
      unique case (cur_in)
         ST_NORMAL: ;
         ST_MANUAL: yellow = blink_in;
         ST_DISABLED: yellow = 1'b1;
         ST_ALERT: red = blink_in;
      endcase
      dist_out = (s2_mode_ff == EV_ECHO) ? dist_sat : '0;
   end

   a_lamps_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[4] && rsp_tdata[5]))
      else $error("red and yellow lamps both on");

   a_disabled_yellow: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[1:0] == ST_DISABLED) |-> rsp_tdata[5] && !rsp_tdata[4])
      else $error("lamps wrong in disabled state");

   a_unchanged_holds: assert property (@(posedge clock) disable iff (reset)
      s2_move && !chg |=> cur_ff == $past(cur_ff))
      else $error("state moved without changed flag");

   a_state_idle_hold: assert property (@(posedge clock) disable iff (reset)
      !s2_move |=> cur_ff == $past(cur_ff) && base_ff == $past(base_ff))
      else $error("state updated without a transaction");

endmodule
